@@ hdl/lfpd_pkg.sv @@
// Shared types, constants and codes for the line follower PID drive core.
`default_nettype none

package lfpd_pkg;

	// Default fraction width of the fixed-point gains and integrator.
	localparam int FRAC_BITS_DEF = 16;

	// Field and port widths.
	localparam int SENSOR_W    = 5;
	localparam int MODE_W      = 2;
	localparam int SPEED_W     = 8;
	localparam int GAIN_W      = 24;
	localparam int LIMIT_W     = 7;
	localparam int ERR_W       = 4;
	localparam int DERR_W      = ERR_W + 1;
	localparam int CORR_W      = 8;
	localparam int REQ_W       = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	// Product widths: an unsigned gain times a signed error or error change.
	localparam int PTERM_W = GAIN_W + 1 + ERR_W;
	localparam int DTERM_W = GAIN_W + 1 + DERR_W;

	// Register reset values.
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST    = 8'd187;
	localparam logic [SPEED_W-1:0] CLIMB_SPEED_RST   = 8'd210;
	localparam logic [SPEED_W-1:0] EXIT_SPEED_RST    = 8'd182;
	localparam logic [SPEED_W-1:0] SPEED_CEILING_RST = 8'd235;
	localparam logic [GAIN_W-1:0]  GAIN_P_RST        = 24'd458752;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST        = 24'd46;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST        = 24'd229376;
	localparam logic [LIMIT_W-1:0] PID_LIMIT_RST     = 7'd40;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_SPEED    = 3'd0,
		REG_CLIMB_SPEED   = 3'd1,
		REG_EXIT_SPEED    = 3'd2,
		REG_SPEED_CEILING = 3'd3,
		REG_GAIN_P        = 3'd4,
		REG_GAIN_I        = 3'd5,
		REG_GAIN_D        = 3'd6,
		REG_PID_LIMIT     = 3'd7
	} lfpd_reg_t;

	// Drive mode codes.
	localparam logic [MODE_W-1:0] MODE_LINE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLIMB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXIT  = 2'd2;

	// Run request codes.
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STOP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RUN  = 2'd2;

	// Error magnitude at and above which the robot pivots in line mode and the integrator clears.
	localparam logic signed [ERR_W-1:0] ERR_PIVOT = 4'sd5;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_bits;
		logic [MODE_W-1:0]   drive_mode;
	} lfpd_in_t;

	typedef struct packed {
		logic [SPEED_W-1:0]       left_duty;
		logic [SPEED_W-1:0]       right_duty;
		logic                     left_backward;
		logic                     right_backward;
		logic signed [ERR_W-1:0]  track_error;
		logic signed [CORR_W-1:0] correction;
		logic [REQ_W-1:0]         run_request;
	} lfpd_out_t;

	typedef struct packed {
		logic [SPEED_W-1:0] base_speed;
		logic [SPEED_W-1:0] climb_speed;
		logic [SPEED_W-1:0] exit_speed;
		logic [SPEED_W-1:0] speed_ceiling;
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [LIMIT_W-1:0] pid_limit;
	} lfpd_cfg_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_duty;
		logic [SPEED_W-1:0] right_duty;
		logic               left_backward;
		logic               right_backward;
	} lfpd_drive_t;

endpackage

`default_nettype wire

@@ hdl/line_follow_pid_drive_core.sv @@
// Top level of the line follower PID drive core.
`default_nettype none

// One control tick per input transfer: five sensor bits and a drive mode go in, one
// result comes out with both wheel duties and directions, the decoded track error, the
// clamped PID correction and a run request. The core accepts one tick every clock cycle
// while the output is not stalled, and passes each result through the stage 1, stage 2
// and result registers. The one-per-cycle figure is set by the state loop at the input: sensor
// decode against the held error, the ki times error product, the integrator add and its
// clamp are all combinational around the held state. The P and D products are registered in a second stage,
// and the sum, truncation toward zero, clamp and wheel logic fill the result register.
// Configuration registers are to be written through the write port only while no tick is in
// flight, which the core itself does not enforce; the pipeline reads them as it goes.
module line_follow_pid_drive_core #(
	parameter int FRAC_BITS = lfpd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire lfpd_pkg::lfpd_in_t               in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output lfpd_pkg::lfpd_out_t                   out_data,
	input  wire logic                             cfg_we,
	input  wire logic [lfpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import lfpd_pkg::*;

	localparam int IW = FRAC_BITS + 5;

	lfpd_cfg_t   cfg;
	lfpd_drive_t drive;

	logic                     accept;
	logic                     out_ready;
	logic                     s2_ready;
	logic                     s1_ready;

	logic signed [ERR_W-1:0]  err_c;
	logic signed [DERR_W-1:0] derr_c;
	logic signed [IW-1:0]     integ_c;
	logic [REQ_W-1:0]         req_c;
	logic signed [PTERM_W-1:0] pterm_c;
	logic signed [DTERM_W-1:0] dterm_c;
	logic signed [CORR_W-1:0] corr_c;

	// Stage 1: decoded error, error change and updated integrator.
	logic                     v_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DERR_W-1:0] derr_s1;
	logic signed [IW-1:0]     integ_s1;
	logic [REQ_W-1:0]         req_s1;
	logic [MODE_W-1:0]        mode_s1;

	// Stage 2: P and D products.
	logic                      v_s2;
	logic signed [PTERM_W-1:0] pterm_s2;
	logic signed [DTERM_W-1:0] dterm_s2;
	logic signed [IW-1:0]      integ_s2;
	logic signed [ERR_W-1:0]   err_s2;
	logic [REQ_W-1:0]          req_s2;
	logic [MODE_W-1:0]         mode_s2;

	// Result register.
	logic      out_valid_q;
	lfpd_out_t out_data_q;

	lfpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Each stage moves when the one after it is empty or moving.
	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !v_s2 || out_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign in_stall  = !s1_ready;
	assign accept    = in_valid && s1_ready;

	lfpd_track #(
		.FRAC_BITS (FRAC_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sensor_bits (in_data.sensor_bits),
		.drive_mode  (in_data.drive_mode),
		.gain_i      (cfg.gain_i),
		.err         (err_c),
		.derr        (derr_c),
		.integ       (integ_c),
		.req         (req_c)
	);

	assign pterm_c = PTERM_W'($signed({1'b0, cfg.gain_p})) * PTERM_W'(err_s1);
	assign dterm_c = DTERM_W'($signed({1'b0, cfg.gain_d})) * DTERM_W'(derr_s1);

	lfpd_corr #(
		.FRAC_BITS (FRAC_BITS)
	) u_corr (
		.pterm     (pterm_s2),
		.dterm     (dterm_s2),
		.integ     (integ_s2),
		.pid_limit (cfg.pid_limit),
		.corr      (corr_c)
	);

	lfpd_drive u_drive (
		.drive_mode (mode_s2),
		.err        (err_s2),
		.corr       (corr_c),
		.cfg        (cfg),
		.drive      (drive)
	);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= accept;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (out_ready) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// Payload registers load only with a transfer into their stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1   <= err_c;
			derr_s1  <= derr_c;
			integ_s1 <= integ_c;
			req_s1   <= req_c;
			mode_s1  <= in_data.drive_mode;
		end
		if (s2_ready && v_s1) begin
			pterm_s2 <= pterm_c;
			dterm_s2 <= dterm_c;
			integ_s2 <= integ_s1;
			err_s2   <= err_s1;
			req_s2   <= req_s1;
			mode_s2  <= mode_s1;
		end
		if (out_ready && v_s2) begin
			out_data_q.left_duty      <= drive.left_duty;
			out_data_q.right_duty     <= drive.right_duty;
			out_data_q.left_backward  <= drive.left_backward;
			out_data_q.right_backward <= drive.right_backward;
			out_data_q.track_error    <= err_s2;
			out_data_q.correction     <= corr_c;
			out_data_q.run_request    <= req_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The correction never leaves the configured clamp.
	a_corr_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.correction <= $signed({1'b0, cfg.pid_limit}))
			&& (out_data.correction >= -$signed({1'b0, cfg.pid_limit})))
		else $error("correction outside the PID limit");

	// Both wheels never reverse at once.
	a_single_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.left_backward && out_data.right_backward))
		else $error("both wheels reversed");

	// A right pivot only comes from a large positive error.
	a_pivot_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.right_backward |-> out_data.track_error >= ERR_PIVOT)
		else $error("right pivot without a large positive error");

	// An input transfer always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("input transfer lost");

endmodule

`default_nettype wire

@@ hdl/lfpd_cfg.sv @@
// Configuration register file of the line follower PID drive core.
`default_nettype none

module lfpd_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lfpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output lfpd_pkg::lfpd_cfg_t                   cfg
);
	import lfpd_pkg::*;

	lfpd_cfg_t cfg_q;

	// Each register takes the low bits of the write data that fit it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed    <= BASE_SPEED_RST;
			cfg_q.climb_speed   <= CLIMB_SPEED_RST;
			cfg_q.exit_speed    <= EXIT_SPEED_RST;
			cfg_q.speed_ceiling <= SPEED_CEILING_RST;
			cfg_q.gain_p        <= GAIN_P_RST;
			cfg_q.gain_i        <= GAIN_I_RST;
			cfg_q.gain_d        <= GAIN_D_RST;
			cfg_q.pid_limit     <= PID_LIMIT_RST;
		end else if (cfg_we) begin
			case (lfpd_reg_t'(cfg_index))
				REG_BASE_SPEED:    cfg_q.base_speed    <= cfg_wdata[SPEED_W-1:0];
				REG_CLIMB_SPEED:   cfg_q.climb_speed   <= cfg_wdata[SPEED_W-1:0];
				REG_EXIT_SPEED:    cfg_q.exit_speed    <= cfg_wdata[SPEED_W-1:0];
				REG_SPEED_CEILING: cfg_q.speed_ceiling <= cfg_wdata[SPEED_W-1:0];
				REG_GAIN_P:        cfg_q.gain_p        <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:        cfg_q.gain_i        <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:        cfg_q.gain_d        <= cfg_wdata[GAIN_W-1:0];
				REG_PID_LIMIT:     cfg_q.pid_limit     <= cfg_wdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hdl/lfpd_track.sv @@
// Sensor decode, held error and integrator state of the line follower PID drive core.
`default_nettype none

module lfpd_track #(
	parameter int FRAC_BITS = lfpd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 accept,
	input  wire logic [lfpd_pkg::SENSOR_W-1:0]        sensor_bits,
	input  wire logic [lfpd_pkg::MODE_W-1:0]          drive_mode,
	input  wire logic [lfpd_pkg::GAIN_W-1:0]          gain_i,
	output logic signed [lfpd_pkg::ERR_W-1:0]         err,
	output logic signed [lfpd_pkg::DERR_W-1:0]        derr,
	output logic signed [FRAC_BITS+4:0]               integ,
	output logic [lfpd_pkg::REQ_W-1:0]                req
);
	import lfpd_pkg::*;

	// Integrator holds +-15.0 in Q(FRAC_BITS): four integer bits plus sign.
	localparam int IW   = FRAC_BITS + 5;
	localparam int IPW  = GAIN_W + 1 + ERR_W;
	localparam int IAW  = ((IW > IPW) ? IW : IPW) + 1;
	localparam logic signed [IAW-1:0] ILIM = $signed({{(IAW-4){1'b0}}, 4'd15}) <<< FRAC_BITS;

	// The held error doubles as the previous error: both take the new error each transfer.
	logic signed [ERR_W-1:0] held_q;
	logic signed [IW-1:0]    integ_q;

	logic signed [IPW-1:0] iprod;
	logic signed [IAW-1:0] isum;
	logic                  in_band;

	// Map the sensor pattern to a position error and a run request.
	always_comb begin
		err = held_q;
		req = REQ_NONE;
		case (sensor_bits)
			5'b10000: err = 4'sd6;
			5'b11000: err = 4'sd5;
			5'b11110: err = 4'sd4;
			5'b11100: err = 4'sd3;
			5'b11101: err = 4'sd2;
			5'b11001: err = 4'sd1;
			5'b11011: err = 4'sd0;
			5'b10011: err = -4'sd1;
			5'b10111: err = -4'sd2;
			5'b00111: err = -4'sd3;
			5'b01111: err = -4'sd4;
			5'b00011: err = -4'sd5;
			5'b00001: err = -4'sd6;
			5'b11111: begin
				// Line lost: push the error to the far edge on its side; a zero held error stays zero.
				if (held_q > 4'sd0) begin
					err = 4'sd7;
				end else if (held_q < 4'sd0) begin
					err = -4'sd7;
				end
			end
			5'b01110, 5'b01010: req = REQ_STOP;
			5'b00000: begin
				if (drive_mode == MODE_CLIMB) begin
					req = REQ_RUN;
				end else if (drive_mode == MODE_LINE) begin
					req = REQ_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	assign derr = DERR_W'(err) - DERR_W'(held_q);

	// Integrator: add ki*error and clamp inside the band, clear outside it.
	assign in_band = (err > -ERR_PIVOT) && (err < ERR_PIVOT);
	assign iprod   = IPW'($signed({1'b0, gain_i})) * IPW'(err);
	assign isum    = IAW'(integ_q) + IAW'(iprod);

	always_comb begin
		if (!in_band) begin
			integ = '0;
		end else if (isum > ILIM) begin
			integ = IW'(ILIM);
		end else if (isum < -ILIM) begin
			integ = IW'(-ILIM);
		end else begin
			integ = IW'(isum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			integ_q <= '0;
		end else if (accept) begin
			held_q  <= err;
			integ_q <= integ;
		end
	end

endmodule

`default_nettype wire

@@ hdl/lfpd_corr.sv @@
// PID sum, truncation toward zero and clamp of the line follower PID drive core.
`default_nettype none

module lfpd_corr #(
	parameter int FRAC_BITS = lfpd_pkg::FRAC_BITS_DEF
) (
	input  wire logic signed [lfpd_pkg::PTERM_W-1:0] pterm,
	input  wire logic signed [lfpd_pkg::DTERM_W-1:0] dterm,
	input  wire logic signed [FRAC_BITS+4:0]         integ,
	input  wire logic [lfpd_pkg::LIMIT_W-1:0]        pid_limit,
	output logic signed [lfpd_pkg::CORR_W-1:0]       corr
);
	import lfpd_pkg::*;

	localparam int IW = FRAC_BITS + 5;
	localparam int AW = ((IW > DTERM_W) ? IW : DTERM_W) + 2;

	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] floor_q;
	logic signed [AW-1:0] quot;
	logic signed [AW-1:0] lim;
	logic                 round_up;

	assign acc = AW'(pterm) + AW'(dterm) + AW'(integ);

	// Arithmetic shift floors; a negative value with a fraction steps back up one.
	assign floor_q  = acc >>> FRAC_BITS;
	assign round_up = acc[AW-1] && (|acc[FRAC_BITS-1:0]);
	assign quot     = floor_q + $signed({{(AW-1){1'b0}}, round_up});

	assign lim = $signed({{(AW-LIMIT_W){1'b0}}, pid_limit});

	always_comb begin
		if (quot > lim) begin
			corr = CORR_W'(lim);
		end else if (quot < -lim) begin
			corr = CORR_W'(-lim);
		end else begin
			corr = CORR_W'(quot);
		end
	end

endmodule

`default_nettype wire

@@ hdl/lfpd_drive.sv @@
// Wheel duty and direction logic of the line follower PID drive core.
`default_nettype none

module lfpd_drive (
	input  wire logic [lfpd_pkg::MODE_W-1:0]        drive_mode,
	input  wire logic signed [lfpd_pkg::ERR_W-1:0]  err,
	input  wire logic signed [lfpd_pkg::CORR_W-1:0] corr,
	input  wire lfpd_pkg::lfpd_cfg_t                cfg,
	output lfpd_pkg::lfpd_drive_t                   drive
);
	import lfpd_pkg::*;

	localparam int SW = SPEED_W + 2;

	logic [SPEED_W-1:0]   mag;
	logic signed [SW-1:0] base_w;
	logic signed [SW-1:0] plus_w;
	logic signed [SW-1:0] minus_w;
	logic [SPEED_W-1:0]   plus_d;
	logic [SPEED_W-1:0]   minus_d;
	logic [SPEED_W-1:0]   base_d;

	// Saturate a side speed to the range zero to the ceiling.
	function automatic logic [SPEED_W-1:0] clamp_duty(input logic signed [SW-1:0] v,
			input logic [SPEED_W-1:0] ceiling);
		logic [SPEED_W-1:0] r;
		if (v[SW-1]) begin
			r = '0;
		end else if (v > $signed({2'b00, ceiling})) begin
			r = ceiling;
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

	assign mag     = corr[CORR_W-1] ? SPEED_W'(-corr) : SPEED_W'(corr);
	assign base_w  = $signed({2'b00, cfg.base_speed});
	assign plus_w  = base_w + $signed({2'b00, mag});
	assign minus_w = base_w - $signed({2'b00, mag});
	assign plus_d  = clamp_duty(plus_w, cfg.speed_ceiling);
	assign minus_d = clamp_duty(minus_w, cfg.speed_ceiling);
	assign base_d  = clamp_duty(base_w, cfg.speed_ceiling);

	always_comb begin
		drive = '0;
		case (drive_mode)
			MODE_LINE: begin
				if (err >= ERR_PIVOT) begin
					// Pivot right: right wheel reverses.
					drive.left_duty      = cfg.speed_ceiling;
					drive.right_duty     = cfg.speed_ceiling;
					drive.right_backward = 1'b1;
				end else if (err <= -ERR_PIVOT) begin
					// Pivot left: left wheel reverses.
					drive.left_duty     = cfg.speed_ceiling;
					drive.right_duty    = cfg.speed_ceiling;
					drive.left_backward = 1'b1;
				end else if (err > 4'sd0) begin
					drive.left_duty  = plus_d;
					drive.right_duty = minus_d;
				end else if (err < 4'sd0) begin
					drive.left_duty  = minus_d;
					drive.right_duty = plus_d;
				end else begin
					drive.left_duty  = base_d;
					drive.right_duty = base_d;
				end
			end
			MODE_CLIMB: begin
				drive.left_duty  = cfg.climb_speed;
				drive.right_duty = cfg.climb_speed;
			end
			MODE_EXIT: begin
				drive.left_duty  = cfg.exit_speed;
				drive.right_duty = cfg.exit_speed;
			end
			default: begin
				// Unused mode: wheels stopped.
			end
		endcase
	end

endmodule

`default_nettype wire
